@@ design/rcms_pkg.sv @@
package rcms_pkg;

	localparam int SAMPLE_W = 16;
	localparam int DIFF_W   = SAMPLE_W + 1;
	localparam int SQ_W     = 2 * DIFF_W;
	localparam int CFG_W    = 13;
	localparam int OUT_W    = 13;
	localparam logic [CFG_W-1:0] ROW_LENGTH_RST = 13'd4096;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] first_view_sample;
		logic signed [SAMPLE_W-1:0] last_view_sample;
	} sample_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] best_shift;
		logic        [OUT_W-1:0] center_doubled;
	} result_t;

	// control broadcast to every cell of the chain
	typedef struct packed {
		logic clr;      // start of a pass: clear chain valids and one accumulator
		logic clr_neg;  // which accumulator the clear hits
		logic act;      // read data of a pass is present this cycle
		logic neg;      // that data belongs to the negative-shift pass
		logic shift;    // move accumulators one cell toward cell zero
	} cell_ctl_t;

endpackage

@@ design/rotation_center_mirror_search_unit.sv @@
// Rotation center search by mirror matching of the 0 and 180 degree rows.
// Each transaction (start high, busy low) stores one sample pair.
// The pair that completes row_length N raises busy for the search: shifts are
// tried in batches of CELLS, one cell of the chain per shift; a batch streams
// both rows out of the row memories once per sign through the single read port
// of each memory, drains, then compares up to 2*CELLS candidates, each by a
// cross-multiply followed by a keep decision. The result appears on result for
// exactly one cycle with done high; the receiver cannot stall it, so it must
// take it in that cycle. Write row_length only while idle.
module rotation_center_mirror_search_unit #(
	parameter int MAX_ROW = 4096,
	parameter int CELLS   = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  rcms_pkg::sample_t             sample,
	output logic                          done,
	output rcms_pkg::result_t             result,
	input  logic                          cfg_we,
	input  logic [rcms_pkg::CFG_W-1:0]    cfg_data
);
	import rcms_pkg::*;

	localparam int AW    = (MAX_ROW > 1) ? $clog2(MAX_ROW) : 1;
	localparam int CW    = $clog2(MAX_ROW + 1);
	localparam int ACC_W = SQ_W + AW;
	localparam int PW    = ACC_W + CW;
	localparam int CIW   = (CELLS > 1) ? $clog2(CELLS) : 1;

	localparam logic [2:0] ST_LOAD  = 3'd0;
	localparam logic [2:0] ST_POS   = 3'd1;
	localparam logic [2:0] ST_NEG   = 3'd2;
	localparam logic [2:0] ST_DRAIN = 3'd3;
	localparam logic [2:0] ST_CMP   = 3'd4;
	localparam logic [2:0] ST_OUT   = 3'd5;

	logic [CFG_W-1:0]            row_length_q;
	logic [2:0]                  st_q;
	logic [CW-1:0]               load_q;
	logic [CW-1:0]               n_q;
	logic [CW-1:0]               t_q;
	logic [CW-1:0]               s0_q;
	logic [CIW-1:0]              cidx_q;
	logic                        sel_q;
	logic                        stg_q;
	logic [ACC_W-1:0]            best_sum_q;
	logic [CW-1:0]               best_cnt_q;
	logic signed [OUT_W-1:0]     best_shift_q;
	logic [PW-1:0]               p1_q;
	logic [PW-1:0]               p2_q;
	logic                        done_q;
	result_t                     res_q;
	logic                        act_d_q;
	logic                        neg_d_q;
	logic                        hv_d_q;
	logic signed [SAMPLE_W-1:0]  first_rd_q;
	logic signed [SAMPLE_W-1:0]  last_rd_q;
	logic signed [SAMPLE_W-1:0]  first_mem [MAX_ROW];
	logic signed [SAMPLE_W-1:0]  last_mem  [MAX_ROW];

	logic [CW-1:0]               n_c;
	logic                        accept;
	logic                        in_pass;
	logic                        hv_c;
	logic [CW-1:0]               ty;
	logic [CW-1:0]               nm1;
	logic [CW-1:0]               lr_pos;
	logic [CW-1:0]               lr_neg;
	logic [CW-1:0]               ra_first;
	logic [CW-1:0]               ra_last;
	logic [CW-1:0]               s_c;
	logic [CW-1:0]               cnt_c;
	logic [ACC_W-1:0]            pos_sum;
	logic [ACC_W-1:0]            neg_sum;
	logic [ACC_W-1:0]            cand_sum;
	logic                        take;
	logic                        adv_cell;
	cell_ctl_t                   ctl;
	logic signed [SAMPLE_W-1:0]  x_b;
	logic signed [SAMPLE_W-1:0]  y_h;

	assign accept = start && !busy;
	assign busy   = (st_q != ST_LOAD);

	// clamp row length to the supported range
	always_comb begin
		if (row_length_q < CFG_W'(2)) begin
			n_c = CW'(2);
		end else if (32'(row_length_q) > MAX_ROW) begin
			n_c = CW'(MAX_ROW);
		end else begin
			n_c = CW'(row_length_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_length_q <= ROW_LENGTH_RST;
		end else if (cfg_we) begin
			row_length_q <= cfg_data;
		end
	end

	// read addresses of the current pass; the chained row lags by the batch base
	assign in_pass = (st_q == ST_POS) || (st_q == ST_NEG);
	assign hv_c    = (t_q >= s0_q);
	assign ty      = t_q - s0_q;
	assign nm1     = n_q - CW'(1);
	assign lr_pos  = nm1 - ty;
	assign lr_neg  = nm1 - t_q;

	always_comb begin
		if (st_q == ST_NEG) begin
			ra_first = hv_c ? ty : '0;
			ra_last  = lr_neg;
		end else begin
			ra_first = t_q;
			ra_last  = hv_c ? lr_pos : '0;
		end
	end

	// row memories: one write port for loading, one read port each for search
	always_ff @(posedge clk) begin
		if (accept) begin
			first_mem[load_q[AW-1:0]] <= sample.first_view_sample;
			last_mem[load_q[AW-1:0]]  <= sample.last_view_sample;
		end
		first_rd_q <= first_mem[ra_first[AW-1:0]];
		last_rd_q  <= last_mem[ra_last[AW-1:0]];
	end

	// track which pass the read data belongs to
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_d_q <= 1'b0;
			neg_d_q <= 1'b0;
			hv_d_q  <= 1'b0;
		end else begin
			act_d_q <= in_pass;
			neg_d_q <= (st_q == ST_NEG);
			hv_d_q  <= in_pass && hv_c;
		end
	end

	// positive pass broadcasts the first row, negative pass the last row
	assign x_b = neg_d_q ? last_rd_q  : first_rd_q;
	assign y_h = neg_d_q ? first_rd_q : last_rd_q;

	// candidate under comparison comes out of cell zero
	assign s_c      = s0_q + CW'(cidx_q);
	assign cnt_c    = n_q - s_c;
	assign cand_sum = sel_q ? neg_sum : pos_sum;
	assign take     = (s_c == '0) || (p1_q < p2_q);
	assign adv_cell = (st_q == ST_CMP) && stg_q && (sel_q || (s_c == '0));

	always_comb begin
		ctl         = '0;
		ctl.clr     = in_pass && (t_q == '0);
		ctl.clr_neg = (st_q == ST_NEG);
		ctl.act     = act_d_q;
		ctl.neg     = neg_d_q;
		ctl.shift   = adv_cell;
	end

	rcms_chain #(.CELLS(CELLS), .ACC_W(ACC_W)) u_chain (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.x       (x_b),
		.y_head  (y_h),
		.yv_head (hv_d_q),
		.pos_sum (pos_sum),
		.neg_sum (neg_sum)
	);

	// sequencer: load, two passes per batch, compare, emit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_LOAD;
			load_q <= '0;
			n_q    <= '0;
			t_q    <= '0;
			s0_q   <= '0;
			cidx_q <= '0;
			sel_q  <= 1'b0;
			stg_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (st_q)
				ST_LOAD: begin
					if (accept) begin
						if (load_q + CW'(1) >= n_c) begin
							n_q    <= n_c;
							load_q <= '0;
							s0_q   <= '0;
							t_q    <= '0;
							st_q   <= ST_POS;
						end else begin
							load_q <= load_q + CW'(1);
						end
					end
				end
				ST_POS: begin
					if (t_q == nm1) begin
						t_q  <= '0;
						st_q <= ST_NEG;
					end else begin
						t_q <= t_q + CW'(1);
					end
				end
				ST_NEG: begin
					if (t_q == nm1) begin
						t_q  <= '0;
						st_q <= ST_DRAIN;
					end else begin
						t_q <= t_q + CW'(1);
					end
				end
				ST_DRAIN: begin
					cidx_q <= '0;
					sel_q  <= 1'b0;
					stg_q  <= 1'b0;
					st_q   <= ST_CMP;
				end
				ST_CMP: begin
					stg_q <= !stg_q;
					if (stg_q) begin
						if (!sel_q && (s_c != '0)) begin
							sel_q <= 1'b1;
						end else begin
							sel_q <= 1'b0;
							if (s_c == (n_q >> 1)) begin
								st_q <= ST_OUT;
							end else if (cidx_q == CIW'(CELLS - 1)) begin
								s0_q <= s0_q + CW'(CELLS);
								t_q  <= '0;
								st_q <= ST_POS;
							end else begin
								cidx_q <= cidx_q + CIW'(1);
							end
						end
					end
				end
				ST_OUT: begin
					done_q <= 1'b1;
					st_q   <= ST_LOAD;
				end
				default: begin
					st_q <= ST_LOAD;
				end
			endcase
		end
	end

	// cross-multiply the means, then keep the strictly smaller one
	always_ff @(posedge clk) begin
		if (st_q == ST_CMP) begin
			if (!stg_q) begin
				p1_q <= PW'(cand_sum) * PW'(best_cnt_q);
				p2_q <= PW'(best_sum_q) * PW'(cnt_c);
			end else if (take) begin
				best_sum_q   <= cand_sum;
				best_cnt_q   <= cnt_c;
				best_shift_q <= sel_q ? -$signed(OUT_W'(s_c)) : $signed(OUT_W'(s_c));
			end
		end
		if (st_q == ST_OUT) begin
			res_q.best_shift     <= best_shift_q;
			res_q.center_doubled <= OUT_W'(n_q) - OUT_W'(1) + OUT_W'(best_shift_q);
		end
	end

	assign done   = done_q;
	assign result = res_q;

	// the fill count stays inside the row memories
	a_load_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_LOAD) |-> (32'(load_q) < MAX_ROW))
		else $error("load count out of range");

	// compared shifts stay within half the row length
	a_shift_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_CMP) |-> (s_c <= (n_q >> 1)))
		else $error("candidate shift beyond half row");

	// a result is one cycle wide and is followed by loading
	a_done_once: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> (!done && (st_q == ST_LOAD || $past(accept))))
		else $error("result strobe repeated");

endmodule

@@ design/rcms_cell.sv @@
module rcms_cell #(
	parameter int ACC_W = 46
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  rcms_pkg::cell_ctl_t                   ctl,
	input  logic signed [rcms_pkg::SAMPLE_W-1:0]  x,
	input  logic signed [rcms_pkg::SAMPLE_W-1:0]  y_in,
	input  logic                                  yv_in,
	output logic signed [rcms_pkg::SAMPLE_W-1:0]  y_out,
	output logic                                  yv_out,
	input  logic        [ACC_W-1:0]               pos_in,
	input  logic        [ACC_W-1:0]               neg_in,
	output logic        [ACC_W-1:0]               pos_out,
	output logic        [ACC_W-1:0]               neg_out
);
	import rcms_pkg::*;

	logic signed [SAMPLE_W-1:0] y_q;
	logic                       yv_q;
	logic        [ACC_W-1:0]    pos_q;
	logic        [ACC_W-1:0]    neg_q;
	logic signed [DIFF_W-1:0]   d;
	logic signed [SQ_W-1:0]     sq;
	logic                       hit;

	// squared difference of the broadcast sample and the chained sample
	assign d   = DIFF_W'(x) - DIFF_W'(y_in);
	assign sq  = SQ_W'(d) * SQ_W'(d);
	assign hit = ctl.act && yv_in;

	// hand the chained sample to the next cell
	always_ff @(posedge clk) begin
		y_q <= y_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			yv_q <= 1'b0;
		end else if (ctl.clr) begin
			yv_q <= 1'b0;
		end else begin
			yv_q <= yv_in;
		end
	end

	// accumulate per sign, clear at pass start, unload toward cell zero
	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			pos_q <= pos_in;
		end else if (ctl.clr && !ctl.clr_neg) begin
			pos_q <= '0;
		end else if (hit && !ctl.neg) begin
			pos_q <= pos_q + ACC_W'($unsigned(sq));
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			neg_q <= neg_in;
		end else if (ctl.clr && ctl.clr_neg) begin
			neg_q <= '0;
		end else if (hit && ctl.neg) begin
			neg_q <= neg_q + ACC_W'($unsigned(sq));
		end
	end

	assign y_out   = y_q;
	assign yv_out  = yv_q;
	assign pos_out = pos_q;
	assign neg_out = neg_q;

endmodule

@@ design/rcms_chain.sv @@
module rcms_chain #(
	parameter int CELLS = 64,
	parameter int ACC_W = 46
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  rcms_pkg::cell_ctl_t                   ctl,
	input  logic signed [rcms_pkg::SAMPLE_W-1:0]  x,
	input  logic signed [rcms_pkg::SAMPLE_W-1:0]  y_head,
	input  logic                                  yv_head,
	output logic        [ACC_W-1:0]               pos_sum,
	output logic        [ACC_W-1:0]               neg_sum
);
	import rcms_pkg::*;

	logic signed [SAMPLE_W-1:0] y_l   [CELLS+1];
	logic                       yv_l  [CELLS+1];
	logic        [ACC_W-1:0]    pos_l [CELLS+1];
	logic        [ACC_W-1:0]    neg_l [CELLS+1];

	assign y_l[0]       = y_head;
	assign yv_l[0]      = yv_head;
	assign pos_l[CELLS] = '0;
	assign neg_l[CELLS] = '0;

	// cell i works on shift base + i
	for (genvar i = 0; i < CELLS; i++) begin : g_cell
		rcms_cell #(.ACC_W(ACC_W)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.x       (x),
			.y_in    (y_l[i]),
			.yv_in   (yv_l[i]),
			.y_out   (y_l[i+1]),
			.yv_out  (yv_l[i+1]),
			.pos_in  (pos_l[i+1]),
			.neg_in  (neg_l[i+1]),
			.pos_out (pos_l[i]),
			.neg_out (neg_l[i])
		);
	end

	assign pos_sum = pos_l[0];
	assign neg_sum = neg_l[0];

endmodule
